/* rtl/atld_pkg.sv */
// Package: shared types, constants and blend helpers for the line engine.
package atld_pkg;

	localparam int FB_WIDTH  = 256;
	localparam int FB_HEIGHT = 256;
	localparam int XW = $clog2(FB_WIDTH);
	localparam int YW = $clog2(FB_HEIGHT);
	localparam int AW = $clog2(FB_WIDTH * FB_HEIGHT);
	localparam int PW = 24;
	localparam int CW = 11;  // signed coordinate width
	localparam int ALW = 20; // signed coverage width

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_LINE  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_INK    = 1'b0,
		REG_FORMAT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_STEP,
		ST_RD,
		ST_RDW,
		ST_BLEND,
		ST_WR,
		ST_ADV,
		ST_PRD,
		ST_PRDW,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic setup;
		logic pick;     // choose brush pixel for the current slot
		logic mem_rd;
		logic blend;
		logic mem_wr;
		logic advance;
		logic pix_rd;
		logic pix_wr;
		logic res_load;
	} ctl_t;

	typedef struct packed {
		logic div_done;
		logic steps_left;
		logic pix_ok;
		logic [1:0] slot;
		logic centre;
	} sts_t;

	// Components scaled as the pixel format requires.
	function automatic logic [23:0] split(input logic [23:0] p, input logic fmt);
		logic [15:0] q;
		q = p[15:0];
		if (fmt)
			split = p;
		else
			split = {q[15:11], 3'b0, q[10:5], 2'b0, q[4:0], 3'b0};
	endfunction

endpackage

/* rtl/atld_if.sv */
// Interfaces: valid/ready channels for commands, results and configuration.
interface atld_in_if;
	import atld_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [7:0] x_start;
	logic [7:0] y_start;
	logic [7:0] x_end;
	logic [7:0] y_end;
	logic [23:0] write_pixel;
	modport source(output valid, cmd, x_start, y_start, x_end, y_end, write_pixel,
		input ready);
	modport sink(input valid, cmd, x_start, y_start, x_end, y_end, write_pixel,
		output ready);
endinterface

interface atld_out_if;
	logic valid;
	logic ready;
	logic [23:0] read_pixel;
	logic [1:0] done_cmd;
	modport source(output valid, read_pixel, done_cmd, input ready);
	modport sink(input valid, read_pixel, done_cmd, output ready);
endinterface

interface atld_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [23:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/antialiased_thick_line_draw_core.sv */
// Top level: line engine with configuration registers, controller and datapath.
//  channel | dir | words
//  cmd_in  | in  | cmd, x/y start, x/y end, write_pixel
//  res_out | out | read_pixel, done_cmd
//  cfg     | in  | index, data
// A pixel write or unknown command goes straight to the result; a read first
// reads the store. A line runs the divider, then per major step a read, blend
// and write on one store port for each side pixel on the store, and a write of
// the ink to the centre pixel.
// Reset clears control and config registers, not datapath or frame store.
// A stalled result holds the engine until it is taken.
module antialiased_thick_line_draw_core (
	input logic clk,
	input logic arst_n,
	atld_in_if.sink   cmd_in,
	atld_out_if.source res_out,
	atld_cfg_if.sink  cfg
);
	import atld_pkg::*;
	ctl_t ctl;
	sts_t sts;
	logic [23:0] ink_q;
	logic fmt_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ink_q <= '0;
			fmt_q <= 1'b0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_INK:    ink_q <= cfg.data;
				REG_FORMAT: fmt_q <= cfg.data[0];
				default:    ink_q <= ink_q;
			endcase
		end
	end

	atld_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
		.in_cmd(cmd_in.cmd), .out_valid(res_out.valid), .out_ready(res_out.ready),
		.ctl(ctl), .sts(sts)
	);

	atld_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .cmd(cmd_in.cmd),
		.x_start(cmd_in.x_start), .y_start(cmd_in.y_start), .x_end(cmd_in.x_end),
		.y_end(cmd_in.y_end), .write_pixel(cmd_in.write_pixel), .ink_colour(ink_q),
		.pixel_format(fmt_q), .read_pixel(res_out.read_pixel),
		.done_cmd(res_out.done_cmd)
	);
endmodule

/* rtl/atld_div.sv */
// Restoring divider: 255*minor / (major+1), one quotient bit per cycle.
module atld_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] num,
	input  logic [8:0]  den,
	output logic        done,
	output logic [15:0] quo
);
	logic [4:0] cnt_q;
	logic busy_q;
	logic [15:0] q_q;
	logic [9:0] r_q;
	logic [9:0] sh;

	assign sh = {r_q[8:0], q_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd16;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			if (sh >= {1'b0, den}) begin
				r_q <= sh - {1'b0, den};
				q_q <= {q_q[14:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[14:0], 1'b0};
			end
		end
	end

	assign done = !busy_q && !start;
	assign quo = q_q;
endmodule

/* rtl/atld_ctrl.sv */
// Controller: sequences commands, line steps and read-modify-write slots.
module atld_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      in_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output atld_pkg::ctl_t  ctl,
	input  atld_pkg::sts_t  sts
);
	import atld_pkg::*;
	state_t st_q, st_d;
	logic [1:0] cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cmd_q <= '0;
		end else begin
			st_q <= st_d;
			if (in_valid && in_ready)
				cmd_q <= in_cmd;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_valid) begin
				case (in_cmd)
					CMD_LINE:  st_d = ST_DIV;
					CMD_READ:  st_d = ST_PRD;
					CMD_WRITE: st_d = ST_OUT;
					default:   st_d = ST_OUT;
				endcase
			end
			ST_DIV:   st_d = ST_SETUP;
			ST_SETUP: if (sts.div_done) st_d = ST_STEP;
			ST_STEP:  st_d = sts.steps_left ? ST_RD : ST_OUT;
			ST_RD:    st_d = !sts.pix_ok ? ST_ADV : (sts.centre ? ST_WR : ST_RDW);
			ST_RDW:   st_d = ST_BLEND;
			ST_BLEND: st_d = ST_WR;
			ST_WR:    st_d = ST_ADV;
			ST_ADV:   st_d = (sts.slot == 2'd2) ? ST_STEP : ST_RD;
			ST_PRD:   st_d = ST_PRDW;
			ST_PRDW:  st_d = ST_OUT;
			ST_OUT:   if (out_ready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
				ctl.pix_wr = in_valid && (in_cmd == CMD_WRITE);
				ctl.res_load = in_valid;
			end
			ST_DIV:   ctl.div_start = 1'b1;
			ST_SETUP: ctl.setup = sts.div_done;
			ST_RD:    ctl.mem_rd = 1'b1;
			ST_RDW:   ctl.pick = 1'b0;
			ST_BLEND: ctl.blend = 1'b1;
			ST_WR:    ctl.mem_wr = 1'b1;
			ST_ADV:   ctl.advance = 1'b1;
			ST_PRD:   ctl.pix_rd = 1'b1;
			ST_PRDW:  ctl.res_load = (cmd_q == CMD_READ);
			ST_OUT:   out_valid = 1'b1;
			default:  ctl = '0;
		endcase
	end
endmodule

/* rtl/atld_dp.sv */
// Datapath: line stepping, coverage, blending and the frame store.
module atld_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  atld_pkg::ctl_t  ctl,
	output atld_pkg::sts_t  sts,
	input  logic [1:0]      cmd,
	input  logic [7:0]      x_start,
	input  logic [7:0]      y_start,
	input  logic [7:0]      x_end,
	input  logic [7:0]      y_end,
	input  logic [23:0]     write_pixel,
	input  logic [23:0]     ink_colour,
	input  logic            pixel_format,
	output logic [23:0]     read_pixel,
	output logic [1:0]      done_cmd
);
	import atld_pkg::*;

	logic [PW-1:0] mem [FB_WIDTH*FB_HEIGHT];
	logic [PW-1:0] rdata_q;

	logic signed [CW-1:0] x_q, y_q, sx_q, sy_q;
	logic [8:0] adx_q, ady_q, cyc_q, n_q;
	logic xmaj_q;
	logic signed [ALW-1:0] alpha_q, astep_q, areset_q;
	logic [1:0] slot_q;
	logic signed [CW-1:0] px, py;
	logic signed [ALW-1:0] wc;
	logic [23:0] pix_q, res_q;
	logic [1:0] cmd_q;
	logic div_done;
	logic [15:0] quo;
	logic [8:0] adx_c, ady_c;
	logic signed [CW-1:0] dx_c, dy_c;
	logic [8:0] mn, mj;
	logic [AW-1:0] addr;
	logic ok;

	assign dx_c = CW'(signed'({1'b0, x_end})) - CW'(signed'({1'b0, x_start}));
	assign dy_c = CW'(signed'({1'b0, y_end})) - CW'(signed'({1'b0, y_start}));
	assign adx_c = dx_c[CW-1] ? 9'(-dx_c) : 9'(dx_c);
	assign ady_c = dy_c[CW-1] ? 9'(-dy_c) : 9'(dy_c);

	assign mn = xmaj_q ? ady_q : adx_q;
	assign mj = xmaj_q ? adx_q : ady_q;

	atld_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.num(16'(mn) * 16'd255), .den(mj + 9'd1), .done(div_done), .quo(quo)
	);

	// Brush pixel for the slot: side minus, centre, side plus.
	always_comb begin
		logic signed [CW-1:0] ox, oy;
		ox = xmaj_q ? CW'(0) : CW'(1);
		oy = xmaj_q ? sy_q : CW'(0);
		case (slot_q)
			2'd0: begin px = x_q - ox; py = y_q - oy; wc = alpha_q; end
			2'd2: begin px = x_q + ox; py = y_q + oy; wc = ALW'(255) - alpha_q; end
			default: begin px = x_q; py = y_q; wc = alpha_q; end
		endcase
	end

	assign ok = (px >= 0) && (py >= 0) && (px < FB_WIDTH) && (py < FB_HEIGHT);
	assign addr = {py[YW-1:0], px[XW-1:0]};

	assign sts.div_done = div_done;
	assign sts.steps_left = (n_q != '0);
	assign sts.pix_ok = ok;
	assign sts.slot = slot_q;
	assign sts.centre = (slot_q == 2'd1);

	// Blend, two multipliers per component over signed weights.
	logic [23:0] cs, ps, bl;
	logic signed [ALW+9:0] r, g, b;
	logic signed [ALW-1:0] wp;
	assign cs = split(ink_colour, pixel_format);
	assign ps = split(rdata_q, pixel_format);
	assign wp = ALW'(255) - wc;
	always_comb begin
		r = wc * $signed({1'b0, cs[23:16]}) + wp * $signed({1'b0, ps[23:16]});
		g = wc * $signed({1'b0, cs[15:8]}) + wp * $signed({1'b0, ps[15:8]});
		b = wc * $signed({1'b0, cs[7:0]}) + wp * $signed({1'b0, ps[7:0]});
		if (!pixel_format)
			bl = {8'b0, r[15:11], g[15:11] & 5'h1f, g[10], b[15:11]};
		else
			// The shifted blue sum spills into the upper bytes when coverage
			// leaves its usual range.
			bl = {r[15:8], g[15:8], 8'b0} | 24'(b >>> 8);
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_rd || ctl.pix_rd)
			rdata_q <= mem[ctl.pix_rd ? {y_q[YW-1:0], x_q[XW-1:0]} : addr];
		if (ctl.blend)
			pix_q <= bl;
		if (ctl.mem_wr)
			mem[addr] <= sts.centre ? (pixel_format ? ink_colour : {8'b0, ink_colour[15:0]})
				: pix_q;
		if (ctl.pix_wr && x_start < FB_WIDTH && y_start < FB_HEIGHT)
			mem[{y_start[YW-1:0], x_start[XW-1:0]}] <=
				pixel_format ? write_pixel : {8'b0, write_pixel[15:0]};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= CW'(signed'({1'b0, x_start}));
			y_q <= CW'(signed'({1'b0, y_start}));
			adx_q <= adx_c;
			ady_q <= ady_c;
			xmaj_q <= ady_c < adx_c;
			sx_q <= (dx_c > 0) ? CW'(1) : ((dx_c < 0) ? -CW'(1) : CW'(0));
			sy_q <= dy_c[CW-1] ? -CW'(1) : CW'(1);
			cmd_q <= cmd;
		end
		if (ctl.setup) begin
			cyc_q <= mj >> 1;
			n_q <= mj;
			alpha_q <= ALW'(127);
			slot_q <= 2'd0;
			if (xmaj_q)
				astep_q <= -ALW'(quo);
			else
				astep_q <= sx_q[CW-1] ? ALW'(quo) : -ALW'(quo);
			areset_q <= (quo != 0 && (xmaj_q || sx_q > 0)) ? ALW'(255) : ALW'(0);
		end
		if (ctl.advance) begin
			slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
			if (slot_q == 2'd2) begin
				n_q <= n_q - 9'd1;
				if (10'(cyc_q) + 10'(mn) > 10'(mj)) begin
					cyc_q <= 9'(10'(cyc_q) + 10'(mn) - 10'(mj));
					alpha_q <= areset_q;
					if (xmaj_q) begin x_q <= x_q + sx_q; y_q <= y_q + sy_q; end
					else begin y_q <= y_q + sy_q; x_q <= x_q + sx_q; end
				end else begin
					cyc_q <= cyc_q + mn;
					alpha_q <= alpha_q + astep_q;
					if (xmaj_q) x_q <= x_q + sx_q;
					else y_q <= y_q + sy_q;
				end
			end
		end
		if (ctl.res_load) begin
			if (ctl.load)
				res_q <= '0;
			else
				res_q <= (x_q < FB_WIDTH && y_q < FB_HEIGHT)
					? (pixel_format ? rdata_q : {8'b0, rdata_q[15:0]}) : '0;
		end
	end

	assign read_pixel = res_q;
	assign done_cmd = cmd_q;
endmodule
